// File: rtl/core/pett_pkg.sv
// ----------------------------------------------------------------------------
// pett_pkg: shared types and constants for the port event trap table
// Action codes, the request token that walks the cell row, and defaults.
// ----------------------------------------------------------------------------
`default_nettype none

package pett_pkg;

  // Table geometry default
  localparam int TableDepthDefault = 16;

  // Field widths
  localparam int PortW = 16;
  localparam int LineW = 16;
  localparam int ActW  = 2;
  localparam int CfgW  = 16;

  // Request action codes
  localparam logic [ActW-1:0] ACT_SET   = 2'd0;
  localparam logic [ActW-1:0] ACT_TRIG  = 2'd1;
  localparam logic [ActW-1:0] ACT_CHECK = 2'd2;

  // Configuration register indexes
  localparam logic CFG_PEER_EN     = 1'b0;
  localparam logic CFG_PEER_TARGET = 1'b1;

  // Request token handed from cell to cell
  typedef struct packed {
    logic             valid;
    logic [ActW-1:0]  action;
    logic [PortW-1:0] port;
    logic [LineW-1:0] line;
    logic             en;
    logic             done;    // request resolved by an earlier cell or by the peer trap
    logic             append;  // set request took a fresh entry
    logic [LineW-1:0] hline;   // line returned by a check request
  } token_t;

endpackage

`default_nettype wire

// File: rtl/core/pett_cell.sv
// ----------------------------------------------------------------------------
// pett_cell: one trap table entry
// Holds port, target, armed and pending bits; applies the passing request
// and hands the token to the next cell.
// ----------------------------------------------------------------------------
`default_nettype none

module pett_cell #(
  parameter int TABLE_DEPTH = pett_pkg::TableDepthDefault,
  parameter int IDX         = 0
) (
  input  wire logic                               clk,
  input  wire logic                               rst,
  input  wire logic                               advance,
  input  wire logic [$clog2(TABLE_DEPTH+1)-1:0]   used,
  input  wire pett_pkg::token_t                   tok_in,
  output pett_pkg::token_t                        tok_out
);

  localparam int UW = $clog2(TABLE_DEPTH + 1);

  // Entry storage, undefined until appended
  logic [pett_pkg::PortW-1:0] entry_port;
  logic [pett_pkg::LineW-1:0] entry_target;
  logic                       entry_armed;
  logic                       entry_pending;

  pett_pkg::token_t tok_q;
  pett_pkg::token_t tok_next;

  logic                       wr_port;
  logic                       wr_target;
  logic                       wr_pending;
  logic                       pending_next;

  logic in_use;
  logic at_tail;
  logic port_hit;

  assign in_use   = (UW'(IDX) < used);
  assign at_tail  = (UW'(IDX) == used);
  assign port_hit = (entry_port == tok_in.port);

  // Request processing for this entry
  always_comb begin
    tok_next     = tok_in;
    wr_port      = 1'b0;
    wr_target    = 1'b0;
    wr_pending   = 1'b0;
    pending_next = 1'b0;
    if (tok_in.valid) begin
      case (tok_in.action)
        pett_pkg::ACT_SET: begin
          if (!tok_in.done) begin
            if (in_use && port_hit) begin
              wr_target     = 1'b1;
              tok_next.done = 1'b1;
            end else if (at_tail) begin
              wr_port         = 1'b1;
              wr_target       = 1'b1;
              wr_pending      = 1'b1;
              pending_next    = 1'b0;
              tok_next.done   = 1'b1;
              tok_next.append = 1'b1;
            end
          end
        end
        pett_pkg::ACT_TRIG: begin
          if (in_use && port_hit && entry_armed) begin
            wr_pending   = 1'b1;
            pending_next = 1'b1;
          end
        end
        pett_pkg::ACT_CHECK: begin
          if (!tok_in.done && in_use && entry_armed && entry_pending) begin
            wr_pending     = 1'b1;
            pending_next   = 1'b0;
            tok_next.done  = 1'b1;
            tok_next.hline = entry_target;
          end
        end
        default: begin
        end
      endcase
    end
  end

  // Entry storage update
  always_ff @(posedge clk) begin
    if (advance) begin
      if (wr_port) begin
        entry_port <= tok_in.port;
      end
      if (wr_target) begin
        entry_target <= tok_in.line;
        entry_armed  <= tok_in.en;
      end
      if (wr_pending) begin
        entry_pending <= pending_next;
      end
    end
  end

  // Token register toward the next cell
  always_ff @(posedge clk) begin
    if (rst) begin
      tok_q.valid <= 1'b0;
    end else if (advance) begin
      tok_q <= tok_next;
    end
  end

  assign tok_out = tok_q;

endmodule

`default_nettype wire

// File: rtl/core/port_event_trap_table.sv
// ----------------------------------------------------------------------------
// port_event_trap_table: vectored event trap controller
// A row of entry cells; each request walks the row one cell per cycle.
// ----------------------------------------------------------------------------
// Usage:
//   Requests arrive on in_valid/in_ready with action, port_number,
//   trap_line, trap_enable and peer_frame_pending. Each request gives
//   exactly one result on out_valid/out_ready (event_found, handler_line,
//   set_dropped).
//   A request enters cell 0 on the accepting edge and steps one cell per
//   cycle; at the end of the row its result moves into the output register.
//   Only one request is in flight at a time: the next request is taken
//   once the previous one has left the cell row.
//   A finished result waits in the output register; the next request can
//   be taken meanwhile. If that request reaches the end of the row while the
//   previous result is still not taken, it holds in the last cell.
//   The user writes configuration (peer trap enable and target) through
//   cfg_we/cfg_index/cfg_data only while no request is in flight (not enforced).
//   Reset empties the table (fill count zero), clears the peer registers
//   and drops any request in flight; no clearing pass is needed.
// ----------------------------------------------------------------------------
`default_nettype none

module port_event_trap_table #(
  parameter int TABLE_DEPTH = pett_pkg::TableDepthDefault
) (
  input  wire logic                          clk,
  input  wire logic                          rst,
  // configuration
  input  wire logic                          cfg_we,
  input  wire logic                          cfg_index,
  input  wire logic [pett_pkg::CfgW-1:0]     cfg_data,
  // request channel
  input  wire logic                          in_valid,
  output logic                               in_ready,
  input  wire logic [pett_pkg::ActW-1:0]     action,
  input  wire logic [pett_pkg::PortW-1:0]    port_number,
  input  wire logic [pett_pkg::LineW-1:0]    trap_line,
  input  wire logic                          trap_enable,
  input  wire logic                          peer_frame_pending,
  // result channel
  output logic                               out_valid,
  input  wire logic                          out_ready,
  output logic                               event_found,
  output logic [pett_pkg::LineW-1:0]         handler_line,
  output logic                               set_dropped
);

  localparam int UW = $clog2(TABLE_DEPTH + 1);

  logic                       peer_en;
  logic [pett_pkg::LineW-1:0] peer_target;
  logic [UW-1:0]              used;
  logic                       busy;
  logic                       advance;
  logic                       accept;
  logic                       load_out;
  logic                       peer_fire;

  pett_pkg::token_t           tok [0:TABLE_DEPTH];
  pett_pkg::token_t           last;
  logic [TABLE_DEPTH-1:0]     chain_valid;

  // Configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      peer_en     <= 1'b0;
      peer_target <= '0;
    end else if (cfg_we) begin
      case (cfg_index)
        pett_pkg::CFG_PEER_EN:     peer_en     <= cfg_data[0];
        pett_pkg::CFG_PEER_TARGET: peer_target <= cfg_data;
        default: begin
        end
      endcase
    end
  end

  assign in_ready = !rst && !busy;
  assign accept   = in_valid && in_ready;
  assign last     = tok[TABLE_DEPTH];

  // Row holds only when a finished request cannot move to the output
  assign advance  = !(last.valid && out_valid && !out_ready);
  assign load_out = last.valid && advance;

  // Peer trap takes priority and is resolved before the row
  assign peer_fire = (action == pett_pkg::ACT_CHECK) && peer_en && peer_frame_pending;

  always_comb begin
    tok[0].valid  = accept;
    tok[0].action = action;
    tok[0].port   = port_number;
    tok[0].line   = trap_line;
    tok[0].en     = trap_enable;
    tok[0].done   = peer_fire;
    tok[0].append = 1'b0;
    tok[0].hline  = peer_fire ? peer_target : '0;
  end

  // Row of entry cells
  for (genvar i = 0; i < TABLE_DEPTH; i++) begin : g_cell
    pett_cell #(
      .TABLE_DEPTH (TABLE_DEPTH),
      .IDX         (i)
    ) u_cell (
      .clk     (clk),
      .rst     (rst),
      .advance (advance),
      .used    (used),
      .tok_in  (tok[i]),
      .tok_out (tok[i+1])
    );
    assign chain_valid[i] = tok[i+1].valid;
  end

  // In-flight flag and fill count
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      used <= '0;
    end else begin
      if (accept) begin
        busy <= 1'b1;
      end else if (load_out) begin
        busy <= 1'b0;
      end
      if (load_out && last.append) begin
        used <= used + UW'(1);
      end
    end
  end

  // Output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (load_out) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load_out) begin
      event_found  <= (last.action == pett_pkg::ACT_CHECK) && last.done;
      handler_line <= ((last.action == pett_pkg::ACT_CHECK) && last.done) ? last.hline : '0;
      set_dropped  <= (last.action == pett_pkg::ACT_SET) && !last.done;
    end
  end

  // Checks
  a_one_in_flight: assert property (@(posedge clk) disable iff (rst)
    $onehot0(chain_valid))
    else $error("more than one request in the cell row");

  a_used_bound: assert property (@(posedge clk) disable iff (rst)
    used <= UW'(TABLE_DEPTH))
    else $error("fill count beyond table depth");

  a_drop_full: assert property (@(posedge clk) disable iff (rst)
    load_out && (last.action == pett_pkg::ACT_SET) && !last.done
      |-> used == UW'(TABLE_DEPTH))
    else $error("set dropped while table has room");

  a_busy_row: assert property (@(posedge clk) disable iff (rst)
    (chain_valid != '0) |-> busy)
    else $error("request in row while not busy");

endmodule

`default_nettype wire

// File: bench/testbench.sv
// ----------------------------------------------------------------------------
// testbench: port event trap table
// Drives set, trigger and check requests through the valid/ready request
// channel, predicts each result with a behavioral copy of the trap table and
// the peer trap registers, and compares every result field by field. Covers
// directed corner cases, random traffic under several peer trap settings,
// a long result stall that backs up the request side, and a final burst
// with no idling.
// ----------------------------------------------------------------------------
module testbench;

  localparam int TableDepth   = pett_pkg::TableDepthDefault;
  localparam int PoolSize     = 20;
  localparam int HoldCycles   = 300;
  localparam int StallLimit   = 3000;
  localparam int SettleCycles = TableDepth + 4;

  // action code 3 is not used by the block
  localparam logic [pett_pkg::ActW-1:0] ActUnused = 2'd3;

  typedef struct packed {
    logic [pett_pkg::ActW-1:0]  action;
    logic [pett_pkg::PortW-1:0] port_num;
    logic [pett_pkg::LineW-1:0] line;
    logic                       en;
    logic                       peer;
  } trap_req_t;

  typedef struct packed {
    logic                       found;
    logic [pett_pkg::LineW-1:0] hline;
    logic                       dropped;
  } trap_res_t;

  logic clk = 1'b0;
  logic rst = 1'b1;

  logic                         cfg_we = 1'b0;
  logic                         cfg_index = pett_pkg::CFG_PEER_EN;
  logic [pett_pkg::CfgW-1:0]    cfg_data = '0;
  logic                         in_valid = 1'b0;
  logic                         in_ready;
  logic [pett_pkg::ActW-1:0]    action = pett_pkg::ACT_SET;
  logic [pett_pkg::PortW-1:0]   port_number = '0;
  logic [pett_pkg::LineW-1:0]   trap_line = '0;
  logic                         trap_enable = 1'b0;
  logic                         peer_frame_pending = 1'b0;
  logic                         out_valid;
  logic                         out_ready = 1'b0;
  logic                         event_found;
  logic [pett_pkg::LineW-1:0]   handler_line;
  logic                         set_dropped;

  // shadow copy of the trap table and peer registers
  logic [pett_pkg::PortW-1:0] tab_port  [TableDepth];
  logic [pett_pkg::LineW-1:0] tab_line  [TableDepth];
  logic                       tab_armed [TableDepth];
  logic                       tab_pend  [TableDepth];
  int                         fill_count = 0;
  logic                       peer_en_cfg = 1'b0;
  logic [pett_pkg::LineW-1:0] peer_target_cfg = '0;

  trap_res_t                  pending_results[$];
  logic [pett_pkg::PortW-1:0] port_pool [PoolSize];

  bit idling = 1'b1;
  bit hold_request = 1'b0;
  int errors = 0;
  int results_checked = 0;
  int traps_fired = 0;
  int sets_dropped = 0;
  int act_count [4] = '{0, 0, 0, 0};
  int idle_cycles = 0;

  port_event_trap_table #(.TABLE_DEPTH(TableDepth)) dut (
    .clk                (clk),
    .rst                (rst),
    .cfg_we             (cfg_we),
    .cfg_index          (cfg_index),
    .cfg_data           (cfg_data),
    .in_valid           (in_valid),
    .in_ready           (in_ready),
    .action             (action),
    .port_number        (port_number),
    .trap_line          (trap_line),
    .trap_enable        (trap_enable),
    .peer_frame_pending (peer_frame_pending),
    .out_valid          (out_valid),
    .out_ready          (out_ready),
    .event_found        (event_found),
    .handler_line       (handler_line),
    .set_dropped        (set_dropped)
  );

  // 12-unit clock
  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  // Apply one request to the shadow table and return the result it gives
  function automatic trap_res_t predict_trap(input trap_req_t rq);
    trap_res_t res;
    bit hit;
    int i;
    res = '0;
    hit = 1'b0;
    case (rq.action)
      pett_pkg::ACT_SET: begin
        // rewrite the first matching port, else append with pending clear
        for (i = 0; i < fill_count; i++) begin
          if (!hit && tab_port[i] == rq.port_num) begin
            tab_line[i]  = rq.line;
            tab_armed[i] = rq.en;
            hit = 1'b1;
          end
        end
        if (!hit) begin
          if (fill_count < TableDepth) begin
            tab_port[fill_count]  = rq.port_num;
            tab_line[fill_count]  = rq.line;
            tab_armed[fill_count] = rq.en;
            tab_pend[fill_count]  = 1'b0;
            fill_count++;
          end else begin
            res.dropped = 1'b1;
          end
        end
      end
      pett_pkg::ACT_TRIG: begin
        for (i = 0; i < fill_count; i++)
          if (tab_port[i] == rq.port_num && tab_armed[i]) tab_pend[i] = 1'b1;
      end
      pett_pkg::ACT_CHECK: begin
        // peer trap wins; it consumes nothing
        if (peer_en_cfg && rq.peer) begin
          res.found = 1'b1;
          res.hline = peer_target_cfg;
        end else begin
          for (i = 0; i < fill_count; i++) begin
            if (!hit && tab_armed[i] && tab_pend[i]) begin
              tab_pend[i] = 1'b0;
              res.found = 1'b1;
              res.hline = tab_line[i];
              hit = 1'b1;
            end
          end
        end
      end
      default: ;
    endcase
    return res;
  endfunction

  // Random request: mostly ports from the pool, some arbitrary ports
  function automatic trap_req_t random_request();
    trap_req_t rq;
    int pick;
    pick = $urandom_range(0, 99);
    if (pick < 4)       rq.action = ActUnused;
    else if (pick < 32) rq.action = pett_pkg::ACT_SET;
    else if (pick < 62) rq.action = pett_pkg::ACT_TRIG;
    else                rq.action = pett_pkg::ACT_CHECK;
    if ($urandom_range(0, 9) < 8) rq.port_num = port_pool[$urandom_range(0, PoolSize - 1)];
    else                          rq.port_num = 16'($urandom);
    rq.line = 16'($urandom);
    rq.en   = ($urandom_range(0, 3) != 0);
    rq.peer = 1'($urandom_range(0, 1));
    return rq;
  endfunction

  // Offer one request, hold it until taken, then record its expected result
  task automatic send_request(input logic [pett_pkg::ActW-1:0] act,
                              input logic [pett_pkg::PortW-1:0] port_val,
                              input logic [pett_pkg::LineW-1:0] line_val,
                              input logic en_val, input logic peer_val);
    trap_req_t rq;
    int gap;
    rq = '{action: act, port_num: port_val, line: line_val, en: en_val, peer: peer_val};
    gap = 0;
    if (idling && $urandom_range(0, 3) == 0) gap = $urandom_range(1, 13);
    if (gap != 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid           <= 1'b1;
    action             <= act;
    port_number        <= port_val;
    trap_line          <= line_val;
    trap_enable        <= en_val;
    peer_frame_pending <= peer_val;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    pending_results.push_back(predict_trap(rq));
    act_count[act]++;
  endtask

  task automatic send_random(input int count);
    trap_req_t rq;
    repeat (count) begin
      rq = random_request();
      send_request(rq.action, rq.port_num, rq.line, rq.en, rq.peer);
    end
  endtask

  // Stop offering and wait for every outstanding result
  task automatic drain_results();
    in_valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (2) @(posedge clk);
  endtask

  task automatic write_config(input logic idx, input logic [pett_pkg::CfgW-1:0] data);
    @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    @(posedge clk);
    cfg_we <= 1'b0;
    if (idx == pett_pkg::CFG_PEER_EN) peer_en_cfg = data[0];
    else                              peer_target_cfg = data;
  endtask

  task automatic apply_reset();
    repeat (11) @(posedge clk);
    rst <= 1'b0;
  endtask

  // Field extremes, update vs append, disarm with pending kept, unused code
  task automatic test_directed_basics();
    send_request(pett_pkg::ACT_CHECK, 16'h0000, 16'h0000, 1'b0, 1'b1);
    send_request(ActUnused,           16'hFFFF, 16'hFFFF, 1'b1, 1'b1);
    send_request(pett_pkg::ACT_SET,   16'h0000, 16'hFFFF, 1'b1, 1'b0);
    send_request(pett_pkg::ACT_SET,   16'hFFFF, 16'h0000, 1'b1, 1'b1);
    send_request(pett_pkg::ACT_TRIG,  16'hFFFF, 16'hFFFF, 1'b0, 1'b0);
    send_request(pett_pkg::ACT_TRIG,  16'h0000, 16'h0000, 1'b1, 1'b1);
    send_request(pett_pkg::ACT_TRIG,  16'h1234, 16'h0000, 1'b1, 1'b0);
    // lowest index first, then the next, then nothing
    send_request(pett_pkg::ACT_CHECK, 16'h0000, 16'h0000, 1'b0, 1'b0);
    send_request(pett_pkg::ACT_CHECK, 16'hFFFF, 16'hFFFF, 1'b1, 1'b0);
    send_request(pett_pkg::ACT_CHECK, 16'h0000, 16'h0000, 1'b0, 1'b0);
    // disarmed entry ignores a trigger
    send_request(pett_pkg::ACT_SET,   16'h0000, 16'h1234, 1'b0, 1'b0);
    send_request(pett_pkg::ACT_TRIG,  16'h0000, 16'h0000, 1'b0, 1'b0);
    send_request(pett_pkg::ACT_CHECK, 16'h0000, 16'h0000, 1'b0, 1'b0);
    // pending survives a disarm and fires after re-arm
    send_request(pett_pkg::ACT_SET,   16'hFFFF, 16'hABCD, 1'b1, 1'b0);
    send_request(pett_pkg::ACT_TRIG,  16'hFFFF, 16'h0000, 1'b0, 1'b0);
    send_request(pett_pkg::ACT_SET,   16'hFFFF, 16'hABCD, 1'b0, 1'b0);
    send_request(pett_pkg::ACT_CHECK, 16'h0000, 16'h0000, 1'b0, 1'b0);
    send_request(pett_pkg::ACT_SET,   16'hFFFF, 16'h5555, 1'b1, 1'b0);
    send_request(pett_pkg::ACT_CHECK, 16'h0000, 16'h0000, 1'b0, 1'b0);
  endtask

  // Peer trap takes priority and leaves the port entry pending
  task automatic test_peer_trap();
    drain_results();
    write_config(pett_pkg::CFG_PEER_EN, 16'h0001);
    write_config(pett_pkg::CFG_PEER_TARGET, 16'hFFFF);
    send_request(pett_pkg::ACT_TRIG,  16'hFFFF, 16'h0000, 1'b0, 1'b0);
    send_request(pett_pkg::ACT_CHECK, 16'h0000, 16'h0000, 1'b0, 1'b1);
    send_request(pett_pkg::ACT_CHECK, 16'h0000, 16'h0000, 1'b0, 1'b0);
    drain_results();
    write_config(pett_pkg::CFG_PEER_TARGET, 16'h0000);
    send_request(pett_pkg::ACT_CHECK, 16'h0000, 16'h0000, 1'b0, 1'b1);
  endtask

  task automatic test_random_traffic(input int count, input logic en_val,
                                     input logic [pett_pkg::CfgW-1:0] target,
                                     input bit with_idle);
    drain_results();
    write_config(pett_pkg::CFG_PEER_EN, {15'd0, en_val});
    write_config(pett_pkg::CFG_PEER_TARGET, target);
    idling = with_idle;
    send_random(count);
  endtask

  // Result side stalls for a long stretch while requests keep coming
  task automatic test_backpressure();
    drain_results();
    idling = 1'b0;
    hold_request = 1'b1;
    send_random(40);
  endtask

  task automatic finish_run();
    drain_results();
    repeat (SettleCycles) @(posedge clk);
    $display("Requests: %0d set, %0d trigger, %0d check, %0d unused code; %0d results checked",
             act_count[pett_pkg::ACT_SET], act_count[pett_pkg::ACT_TRIG],
             act_count[pett_pkg::ACT_CHECK], act_count[ActUnused], results_checked);
    $display("Traps fired: %0d, sets dropped on a full table: %0d, table fill: %0d",
             traps_fired, sets_dropped, fill_count);
    if (errors == 0) $display("All tests passed");
    else             $display("Some tests failed");
    $finish;
  endtask

  initial begin
    apply_reset();
    test_directed_basics();
    test_peer_trap();
    // random pool keeps the two directed ports, so the table fills and then drops
    foreach (port_pool[k]) port_pool[k] = 16'($urandom);
    port_pool[0] = 16'h0000;
    port_pool[1] = 16'hFFFF;
    test_random_traffic(400, 1'b0, 16'hFFFF, 1'b1);
    test_random_traffic(400, 1'b1, 16'hFFFF, 1'b1);
    test_random_traffic(400, 1'b1, 16'($urandom_range(1, 16'hFFFE)), 1'b1);
    test_random_traffic(350, 1'b0, 16'h0000, 1'b1);
    test_backpressure();
    test_random_traffic(300, 1'b1, 16'($urandom_range(1, 16'hFFFE)), 1'b0);
    finish_run();
  end

  // Result side: long hold on request, else random stall bursts while idling
  always begin
    @(posedge clk);
    if (hold_request) begin
      hold_request = 1'b0;
      out_ready <= 1'b0;
      repeat (HoldCycles) @(posedge clk);
      out_ready <= 1'b1;
    end else if (idling && $urandom_range(0, 3) == 0) begin
      out_ready <= 1'b0;
      repeat ($urandom_range(1, 13)) @(posedge clk);
      out_ready <= 1'b1;
    end else begin
      out_ready <= 1'b1;
    end
  end

  // Compare each taken result with the oldest expectation
  always @(posedge clk) begin
    trap_res_t want;
    if (!rst && out_valid && out_ready) begin
      if (pending_results.size() == 0) begin
        $error("result with nothing expected: found=%0d line=%h dropped=%0d",
               event_found, handler_line, set_dropped);
        errors++;
      end else begin
        want = pending_results.pop_front();
        results_checked++;
        if (want.found)   traps_fired++;
        if (want.dropped) sets_dropped++;
        if (event_found !== want.found) begin
          $error("event_found: expected %0d, got %0d", want.found, event_found);
          errors++;
        end
        if (handler_line !== want.hline) begin
          $error("handler_line: expected %h, got %h", want.hline, handler_line);
          errors++;
        end
        if (set_dropped !== want.dropped) begin
          $error("set_dropped: expected %0d, got %0d", want.dropped, set_dropped);
          errors++;
        end
      end
    end
  end

  // Watchdog on cycles with no handshake on either side
  always @(posedge clk) begin
    if (rst || (in_valid && in_ready) || (out_valid && out_ready)) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= StallLimit) begin
      $display("Some tests failed");
      $finish;
    end
  end

endmodule
